[rtl/spl_pkg.sv]
// ----------------------------------------------------------------------------
// spl_pkg: shared types and codes of the sorted priority task list
// Holds the entry record, the operation and status codes and the sequencer
// state type; the control module uses them all, storage only the entry record.
// ----------------------------------------------------------------------------
package spl_pkg;

	// default number of list entries
	localparam int unsigned DEPTH_DEF = 16;

	// operation codes on the request channel
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_DELETE = 2'd1;
	localparam logic [1:0] FUNC_READ   = 2'd2;

	// status codes on the response channel
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	// one stored task
	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  prio;
		logic [15:0] tag;
	} entry_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CHK,
		S_PUT,
		S_DONE
	} seq_state_t;

endpackage

[rtl/spl_if.sv]
// ----------------------------------------------------------------------------
// spl_if: request and response channels of the sorted priority task list
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface spl_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] task_id;
	logic [7:0]  priority_req;
	logic [15:0] task_tag;
	logic [3:0]  position;

	modport source (output valid, func, task_id, priority_req, task_tag, position,
		input ready);
	modport sink (input valid, func, task_id, priority_req, task_tag, position,
		output ready);
endinterface

interface spl_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] out_id;
	logic [7:0]  out_priority;
	logic [15:0] out_tag;
	logic [4:0]  count;

	modport source (output valid, status, out_id, out_priority, out_tag, count,
		input ready);
	modport sink (input valid, status, out_id, out_priority, out_tag, count,
		output ready);
endinterface

[rtl/spl_mem.sv]
// ----------------------------------------------------------------------------
// spl_mem: entry storage
// One write port and one read port; read data is registered, so it appears
// in the cycle after the address.
// ----------------------------------------------------------------------------
module spl_mem #(
	parameter int unsigned DEPTH = spl_pkg::DEPTH_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  spl_pkg::entry_t   wdata,
	input  logic [AW-1:0]     raddr,
	output spl_pkg::entry_t   rdata
);
	import spl_pkg::*;

	entry_t mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/spl_ctrl.sv]
// ----------------------------------------------------------------------------
// spl_ctrl: list sequencer
// Walks the stored entries one read-compare-write step at a time: insert
// walks from the tail toward the head shifting larger entries up, delete
// walks from the head shifting entries down behind the match.
// ----------------------------------------------------------------------------
module spl_ctrl #(
	parameter int unsigned DEPTH = spl_pkg::DEPTH_DEF,
	parameter int unsigned AW    = $clog2(DEPTH),
	parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	spl_req_if.sink           req,
	spl_rsp_if.source         rsp,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output spl_pkg::entry_t   mem_wdata,
	output logic [AW-1:0]     mem_raddr,
	input  spl_pkg::entry_t   mem_rdata
);
	import spl_pkg::*;

	seq_state_t    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [AW-1:0] slot_q, slot_d;
	logic          found_q, found_d;
	logic [1:0]    func_q;
	entry_t        new_q;
	logic [1:0]    res_status_q, res_status_d;
	entry_t        res_data_q, res_data_d;
	logic          out_valid_q;
	logic [1:0]    out_status_q;
	entry_t        out_data_q;
	logic [4:0]    out_count_q;
	logic          req_xfer;
	logic          out_load;
	logic          pos_hit;
	logic          last_idx;

	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	assign pos_hit   = 32'(req.position) < 32'(count_q);
	assign last_idx  = (idx_q == count_q - CW'(1));

	// hold the request fields for the walk
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			func_q <= req.func;
			new_q  <= '{id: req.task_id, prio: req.priority_req, tag: req.task_tag};
		end
	end

	// sequencer state and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			slot_q  <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			slot_q  <= slot_d;
			found_q <= found_d;
		end
	end

	// result staging
	always_ff @(posedge clk) begin
		res_status_q <= res_status_d;
		res_data_q   <= res_data_d;
	end

	// next state, memory access and result
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		idx_d        = idx_q;
		slot_d       = slot_q;
		found_d      = found_q;
		res_status_d = res_status_q;
		res_data_d   = res_data_q;
		mem_we       = 1'b0;
		mem_waddr    = AW'(idx_q);
		mem_wdata    = mem_rdata;
		mem_raddr    = AW'(idx_q);
		case (state_q)
			S_IDLE: begin
				if (req_xfer) begin
					res_status_d = ST_OK;
					res_data_d   = '0;
					found_d      = 1'b0;
					case (req.func)
						FUNC_INSERT: begin
							if (count_q == CW'(DEPTH)) begin
								res_status_d = ST_FULL;
								state_d      = S_DONE;
							end else if (count_q == '0) begin
								slot_d  = '0;
								state_d = S_PUT;
							end else begin
								idx_d   = count_q - CW'(1);
								state_d = S_RD;
							end
						end
						FUNC_DELETE: begin
							if (count_q == '0) begin
								res_status_d = ST_EMPTY;
								state_d      = S_DONE;
							end else begin
								idx_d   = '0;
								state_d = S_RD;
							end
						end
						FUNC_READ: begin
							if (pos_hit) begin
								idx_d   = CW'(req.position);
								state_d = S_RD;
							end else begin
								res_status_d = ST_EMPTY;
								state_d      = S_DONE;
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_RD: begin
				state_d = S_CHK;
			end
			S_CHK: begin
				case (func_q)
					FUNC_INSERT: begin
						// shift a larger entry up one place, or drop the new one in
						mem_we    = 1'b1;
						mem_waddr = AW'(idx_q + CW'(1));
						if (mem_rdata.prio > new_q.prio) begin
							mem_wdata = mem_rdata;
							if (idx_q == '0) begin
								slot_d  = '0;
								state_d = S_PUT;
							end else begin
								idx_d   = idx_q - CW'(1);
								state_d = S_RD;
							end
						end else begin
							mem_wdata = new_q;
							count_d   = count_q + CW'(1);
							state_d   = S_DONE;
						end
					end
					FUNC_DELETE: begin
						// past the match, move each entry down one place
						if (found_q) begin
							mem_we    = 1'b1;
							mem_waddr = AW'(idx_q - CW'(1));
							mem_wdata = mem_rdata;
						end else if (mem_rdata.id == new_q.id) begin
							found_d = 1'b1;
						end
						if (last_idx) begin
							if (found_d) begin
								count_d = count_q - CW'(1);
							end else begin
								res_status_d = ST_NOTFOUND;
							end
							state_d = S_DONE;
						end else begin
							idx_d   = idx_q + CW'(1);
							state_d = S_RD;
						end
					end
					default: begin
						res_data_d = mem_rdata;
						state_d    = S_DONE;
					end
				endcase
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = slot_q;
				mem_wdata = new_q;
				count_d   = count_q + CW'(1);
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// output register: holds a result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_data_q   <= res_data_q;
			out_count_q  <= 5'(count_q);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.out_id       = out_data_q.id;
	assign rsp.out_priority = out_data_q.prio;
	assign rsp.out_tag      = out_data_q.tag;
	assign rsp.count        = out_count_q;

endmodule

[rtl/sorted_priority_task_list.sv]
// ----------------------------------------------------------------------------
// sorted_priority_task_list: bounded task list kept in priority order
// Usage:
//   req carries one operation per transfer: insert (task_id, priority_req,
//   task_tag), delete by task_id, or read at position. rsp returns exactly
//   one result per request: status, the entry read (zero otherwise) and the
//   entry count after the operation.
//   Inserts go behind all entries of equal priority; a full list refuses
//   with status full. Delete removes the first entry with a matching id.
// Walk: the sequencer walks the entry memory one entry at a time
//   (read, then compare and write back), one port each way. Insert
//   walks from the tail until it finds its place, delete walks every
//   entry, read visits one; refused or unused operations skip the walk.
//   One item is worked at a time.
// Reset: the count clears to zero; entry contents are left as they are.
// Stall: the result waits in an output register; the next request is
//   transferred meanwhile, and its result waits until the previous one
//   has been transferred.
// ----------------------------------------------------------------------------
module sorted_priority_task_list #(
	parameter int unsigned DEPTH = spl_pkg::DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	spl_req_if.sink   req,
	spl_rsp_if.source rsp
);
	import spl_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;

	// sequencer
	spl_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// entry storage
	spl_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
